### hdl/cci_pkg.sv
// circle intersection package: word widths and the sideband records that travel
// down the pipeline; no dependencies

package cci_pkg;

  // coordinate width; radii are one bit narrower
  localparam int W  = 24;
  localparam int RW = W - 1;
  // squared center distance
  localparam int DW = 2 * W + 1;
  // chord term k and divisor 2*d2
  localparam int KW = 2 * W + 2;
  // chunk width for split multiplies
  localparam int CH = KW / 2;
  // square root argument and root
  localparam int HW = 2 * KW;
  localparam int SW = KW;
  // rounded quotient numerators
  localparam int NW = W + KW + 1;
  // quotient bits produced by the dividers
  localparam int QW = W;

  // sideband carried alongside the square root
  typedef struct packed {
    logic          vld;
    logic          found;
    logic          sgx;
    logic          sgy;
    logic          kneg;
    logic [W-1:0]  x1;
    logic [W-1:0]  y1;
    logic [W-1:0]  adx;
    logic [W-1:0]  ady;
    logic [DW-1:0] d2;
  } sqsb_t;

  // sideband carried alongside the offset dividers
  typedef struct packed {
    logic          vld;
    logic          found;
    logic          sgx;
    logic          sgy;
    logic          kneg;
    logic [W-1:0]  x1;
    logic [W-1:0]  y1;
    logic [QW-1:0] fqx;
    logic [QW-1:0] fqy;
  } dvsb_t;

endpackage

### hdl/cci_div.sv
// pipelined restoring divider, one quotient bit per stage
// depends on cci_pkg

module cci_div (
  input  logic                   clk,
  input  logic                   en,
  input  logic [cci_pkg::NW-1:0] num,
  input  logic [cci_pkg::KW-1:0] den,
  output logic [cci_pkg::QW-1:0] quo
);
  import cci_pkg::*;

  logic [NW-1:0] rem [QW];
  logic [KW-1:0] dn  [QW];
  logic [QW-1:0] q   [QW];

  for (genvar i = 0; i < QW; i++) begin : g_step
    logic [NW-1:0] rem_in;
    logic [KW-1:0] dn_in;
    logic [QW-1:0] q_in;
    logic [NW-1:0] trial;

    if (i == 0) begin : g_first
      assign rem_in = num;
      assign dn_in  = den;
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = rem[i-1];
      assign dn_in  = dn[i-1];
      assign q_in   = q[i-1];
    end

    // divisor aligned to this quotient bit
    assign trial = NW'(dn_in) << (QW - 1 - i);

    // compare and subtract for one bit
    always_ff @(posedge clk) begin
      if (en) begin
        dn[i] <= dn_in;
        if (rem_in >= trial) begin
          rem[i] <= rem_in - trial;
          q[i]   <= q_in | (QW'(1) << (QW - 1 - i));
        end else begin
          rem[i] <= rem_in;
          q[i]   <= q_in;
        end
      end
    end
  end

  assign quo = q[QW-1];

endmodule

### hdl/cci_sqrt.sv
// pipelined integer square root, one root bit per stage
// depends on cci_pkg

module cci_sqrt (
  input  logic                   clk,
  input  logic                   en,
  input  logic [cci_pkg::HW-1:0] op,
  output logic [cci_pkg::SW-1:0] root
);
  import cci_pkg::*;

  logic [HW-1:0] rem [SW];
  logic [HW-1:0] res [SW];

  for (genvar i = 0; i < SW; i++) begin : g_step
    logic [HW-1:0] rem_in;
    logic [HW-1:0] res_in;
    logic [HW-1:0] one;
    logic [HW-1:0] trial;

    if (i == 0) begin : g_first
      assign rem_in = op;
      assign res_in = '0;
    end else begin : g_next
      assign rem_in = rem[i-1];
      assign res_in = res[i-1];
    end

    // partial root bits sit above the trial bit, so or equals add
    assign one   = HW'(1) << (2 * (SW - 1 - i));
    assign trial = res_in | one;

    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_in >= trial) begin
          rem[i] <= rem_in - trial;
          res[i] <= (res_in >> 1) | one;
        end else begin
          rem[i] <= rem_in;
          res[i] <= res_in >> 1;
        end
      end
    end
  end

  assign root = res[SW-1][SW-1:0];

endmodule

### hdl/circle_circle_intersection.sv
// circle intersection top level; depends on cci_pkg, cci_sqrt, cci_div
// the pipeline depth is set by the bit-per-stage square root (SW = 50 stages)
// and divider (QW = 24 stages)
// throughput: one request per cycle; the whole pipeline holds while a
// result waits under stall
// reset: synchronous, clears every stage valid and the result valid

module circle_circle_intersection (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  logic signed [cci_pkg::W-1:0]  first_center_x,
  input  logic signed [cci_pkg::W-1:0]  first_center_y,
  input  logic        [cci_pkg::RW-1:0] first_radius,
  input  logic signed [cci_pkg::W-1:0]  second_center_x,
  input  logic signed [cci_pkg::W-1:0]  second_center_y,
  input  logic        [cci_pkg::RW-1:0] second_radius,
  output logic                          res_valid,
  input  logic                          res_stall,
  output logic                          found,
  output logic signed [cci_pkg::W-1:0]  point_one_x,
  output logic signed [cci_pkg::W-1:0]  point_one_y,
  output logic signed [cci_pkg::W-1:0]  point_two_x,
  output logic signed [cci_pkg::W-1:0]  point_two_y
);
  import cci_pkg::*;

  // saturate a wide sum into the coordinate range
  function automatic logic [W-1:0] sat(input logic [W+1:0] s);
    logic [W-1:0] r;
    if (s[W+1:W-1] == 3'b000 || s[W+1:W-1] == 3'b111) begin
      r = s[W-1:0];
    end else if (s[W+1]) begin
      r = {1'b1, {(W-1){1'b0}}};
    end else begin
      r = {1'b0, {(W-1){1'b1}}};
    end
    return r;
  endfunction

  // rounded magnitude with its sign applied
  function automatic logic [W-1:0] signed_mag(input logic [RW-1:0] m, input logic neg);
    logic [W-1:0] v;
    v = W'(m);
    return neg ? W'(-v) : v;
  endfunction

  logic en;
  assign en        = !res_valid || !res_stall;
  assign req_stall = !en;

  // stage a: request capture
  logic                 a_vld;
  logic signed [W-1:0]  a_x1, a_y1, a_x2, a_y2;
  logic        [RW-1:0] a_r1, a_r2;

  // stage b: deltas and radius sum, difference
  logic signed [W:0] dx, dy;
  sqsb_t          b_sb;
  logic [RW-1:0]  b_r1, b_r2, b_rd;
  logic [W-1:0]   b_rs;

  // stage c: squares
  sqsb_t          c_sb;
  logic [2*W-1:0] c_ax2, c_ay2, c_sum2;
  logic [2*RW-1:0] c_dif2, c_rr1, c_rr2;

  // stage d: squared distance
  sqsb_t          d_sb;
  sqsb_t          d_sb_next;
  logic [2*W-1:0] d_sum2;
  logic [2*RW-1:0] d_dif2, d_rr1, d_rr2;

  // stage e: intersection test
  sqsb_t           e_sb;
  sqsb_t           e_sb_next;
  logic [KW-1:0]   e_t;
  logic [2*RW-1:0] e_rr1, e_rr2;

  // stage f: chord term k
  sqsb_t           f_sb;
  sqsb_t           f_sb_next;
  logic [KW-1:0]   f_k;
  logic [2*RW-1:0] f_rr1;

  // stage g: partial products
  sqsb_t            g_sb;
  logic [2*CH-1:0]  g_h_ll, g_h_lh, g_h_hl, g_h_hh;
  logic [2*CH-1:0]  g_k_ll, g_k_lh, g_k_hh;
  logic [W+CH-1:0]  g_fx_l, g_fx_h, g_fy_l, g_fy_h;

  // stage h: product sums
  sqsb_t         h_sb;
  logic [HW-1:0] h_h4, h_kk;
  logic [NW-1:0] h_nx, h_ny;

  // stage i: root argument clamped at zero
  sqsb_t         i_sb;
  logic [HW-1:0] i_h;
  logic [NW-1:0] i_nx, i_ny;

  sqsb_t         sq_sb [SW];
  logic [SW-1:0] root;
  logic [QW-1:0] foot_qx, foot_qy;
  logic [QW-1:0] fd_x [SW-QW];
  logic [QW-1:0] fd_y [SW-QW];

  // stage j: offset partial products
  sqsb_t           j_sb;
  logic [QW-1:0]   j_fqx, j_fqy;
  logic [W+CH-1:0] j_ox_l, j_ox_h, j_oy_l, j_oy_h;

  // stage k: offset numerators
  dvsb_t         k_lt;
  logic [DW-1:0] k_d2;
  logic [NW-1:0] k_nx, k_ny;

  dvsb_t         lt [QW];
  logic [QW-1:0] off_qx, off_qy;

  // stage l: signed foot and offset
  logic                l_vld, l_found;
  logic signed [W-1:0] l_x1, l_y1, l_fx, l_fy, l_ox, l_oy;

  logic signed [W+1:0] s1x, s1y, s2x, s2y;

  always_comb begin
    dx = (W+1)'(a_x2) - (W+1)'(a_x1);
    dy = (W+1)'(a_y2) - (W+1)'(a_y1);
  end

  // sideband updates for the distance, test and chord stages
  always_comb begin
    d_sb_next       = c_sb;
    d_sb_next.d2    = DW'(c_ax2) + DW'(c_ay2);
    e_sb_next       = d_sb;
    e_sb_next.found = (d_sb.d2 != '0) && (d_sb.d2 <= DW'(d_sum2))
                      && (d_sb.d2 >= DW'(d_dif2));
    f_sb_next       = e_sb;
    f_sb_next.kneg  = e_t < KW'(e_rr2);
  end

  // front stages, up to the root argument
  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld    <= 1'b0;
      b_sb.vld <= 1'b0;
      c_sb.vld <= 1'b0;
      d_sb.vld <= 1'b0;
      e_sb.vld <= 1'b0;
      f_sb.vld <= 1'b0;
      g_sb.vld <= 1'b0;
      h_sb.vld <= 1'b0;
      i_sb.vld <= 1'b0;
    end else if (en) begin
      a_vld <= req_valid;
      a_x1  <= first_center_x;
      a_y1  <= first_center_y;
      a_r1  <= first_radius;
      a_x2  <= second_center_x;
      a_y2  <= second_center_y;
      a_r2  <= second_radius;

      b_sb.vld   <= a_vld;
      b_sb.found <= 1'b0;
      b_sb.kneg  <= 1'b0;
      b_sb.sgx   <= dx[W];
      b_sb.sgy   <= dy[W];
      b_sb.x1    <= a_x1;
      b_sb.y1    <= a_y1;
      b_sb.adx   <= dx[W] ? W'(-dx) : W'(dx);
      b_sb.ady   <= dy[W] ? W'(-dy) : W'(dy);
      b_sb.d2    <= '0;
      b_r1       <= a_r1;
      b_r2       <= a_r2;
      b_rs       <= W'(a_r1) + W'(a_r2);
      b_rd       <= (a_r1 > a_r2) ? a_r1 - a_r2 : a_r2 - a_r1;

      c_sb   <= b_sb;
      c_ax2  <= b_sb.adx * b_sb.adx;
      c_ay2  <= b_sb.ady * b_sb.ady;
      c_sum2 <= b_rs * b_rs;
      c_dif2 <= b_rd * b_rd;
      c_rr1  <= b_r1 * b_r1;
      c_rr2  <= b_r2 * b_r2;

      d_sb    <= d_sb_next;
      d_sum2  <= c_sum2;
      d_dif2  <= c_dif2;
      d_rr1   <= c_rr1;
      d_rr2   <= c_rr2;

      e_sb       <= e_sb_next;
      e_t        <= KW'(d_rr1) + KW'(d_sb.d2);
      e_rr1      <= d_rr1;
      e_rr2      <= d_rr2;

      f_sb      <= f_sb_next;
      f_k       <= (e_t < KW'(e_rr2)) ? KW'(e_rr2) - e_t : e_t - KW'(e_rr2);
      f_rr1     <= e_rr1;

      g_sb   <= f_sb;
      g_h_ll <= f_sb.d2[CH-1:0] * f_rr1[CH-1:0];
      g_h_lh <= f_sb.d2[CH-1:0] * f_rr1[2*RW-1:CH];
      g_h_hl <= f_sb.d2[DW-1:CH] * f_rr1[CH-1:0];
      g_h_hh <= f_sb.d2[DW-1:CH] * f_rr1[2*RW-1:CH];
      g_k_ll <= f_k[CH-1:0] * f_k[CH-1:0];
      g_k_lh <= f_k[CH-1:0] * f_k[KW-1:CH];
      g_k_hh <= f_k[KW-1:CH] * f_k[KW-1:CH];
      g_fx_l <= f_sb.adx * f_k[CH-1:0];
      g_fx_h <= f_sb.adx * f_k[KW-1:CH];
      g_fy_l <= f_sb.ady * f_k[CH-1:0];
      g_fy_h <= f_sb.ady * f_k[KW-1:CH];

      h_sb <= g_sb;
      h_h4 <= ((HW'(g_h_hh) << (2 * CH)) + (HW'(g_h_lh) << CH)
              + (HW'(g_h_hl) << CH) + HW'(g_h_ll)) << 2;
      h_kk <= (HW'(g_k_hh) << (2 * CH)) + (HW'(g_k_lh) << (CH + 1)) + HW'(g_k_ll);
      h_nx <= (NW'(g_fx_h) << CH) + NW'(g_fx_l) + NW'(g_sb.d2);
      h_ny <= (NW'(g_fy_h) << CH) + NW'(g_fy_l) + NW'(g_sb.d2);

      i_sb <= h_sb;
      i_h  <= (h_h4 >= h_kk) ? h_h4 - h_kk : '0;
      i_nx <= h_nx;
      i_ny <= h_ny;
    end
  end

  cci_sqrt u_sqrt (
    .clk  (clk),
    .en   (en),
    .op   (i_h),
    .root (root)
  );

  cci_div u_foot_x (
    .clk (clk),
    .en  (en),
    .num (i_nx),
    .den ({i_sb.d2, 1'b0}),
    .quo (foot_qx)
  );

  cci_div u_foot_y (
    .clk (clk),
    .en  (en),
    .num (i_ny),
    .den ({i_sb.d2, 1'b0}),
    .quo (foot_qy)
  );

  // sideband alongside the root, foot quotients wait for the root
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < SW; k++) begin
        sq_sb[k].vld <= 1'b0;
      end
    end else if (en) begin
      sq_sb[0] <= i_sb;
      for (int k = 1; k < SW; k++) begin
        sq_sb[k] <= sq_sb[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fd_x[0] <= foot_qx;
      fd_y[0] <= foot_qy;
      for (int k = 1; k < SW - QW; k++) begin
        fd_x[k] <= fd_x[k-1];
        fd_y[k] <= fd_y[k-1];
      end
    end
  end

  // offset products and numerators
  always_ff @(posedge clk) begin
    if (rst) begin
      j_sb.vld <= 1'b0;
      k_lt.vld <= 1'b0;
    end else if (en) begin
      j_sb   <= sq_sb[SW-1];
      j_fqx  <= fd_x[SW-QW-1];
      j_fqy  <= fd_y[SW-QW-1];
      j_ox_l <= sq_sb[SW-1].ady * root[CH-1:0];
      j_ox_h <= sq_sb[SW-1].ady * root[SW-1:CH];
      j_oy_l <= sq_sb[SW-1].adx * root[CH-1:0];
      j_oy_h <= sq_sb[SW-1].adx * root[SW-1:CH];

      k_lt.vld   <= j_sb.vld;
      k_lt.found <= j_sb.found;
      k_lt.sgx   <= j_sb.sgx;
      k_lt.sgy   <= j_sb.sgy;
      k_lt.kneg  <= j_sb.kneg;
      k_lt.x1    <= j_sb.x1;
      k_lt.y1    <= j_sb.y1;
      k_lt.fqx   <= j_fqx;
      k_lt.fqy   <= j_fqy;
      k_d2       <= j_sb.d2;
      k_nx       <= (NW'(j_ox_h) << CH) + NW'(j_ox_l) + NW'(j_sb.d2);
      k_ny       <= (NW'(j_oy_h) << CH) + NW'(j_oy_l) + NW'(j_sb.d2);
    end
  end

  cci_div u_off_x (
    .clk (clk),
    .en  (en),
    .num (k_nx),
    .den ({k_d2, 1'b0}),
    .quo (off_qx)
  );

  cci_div u_off_y (
    .clk (clk),
    .en  (en),
    .num (k_ny),
    .den ({k_d2, 1'b0}),
    .quo (off_qy)
  );

  // sideband alongside the offset dividers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < QW; k++) begin
        lt[k].vld <= 1'b0;
      end
    end else if (en) begin
      lt[0] <= k_lt;
      for (int k = 1; k < QW; k++) begin
        lt[k] <= lt[k-1];
      end
    end
  end

  // signs, then sums with saturation into the result register
  always_comb begin
    s1x = (W+2)'(l_x1) + (W+2)'(l_fx) + (W+2)'(l_ox);
    s1y = (W+2)'(l_y1) + (W+2)'(l_fy) + (W+2)'(l_oy);
    s2x = (W+2)'(l_x1) + (W+2)'(l_fx) - (W+2)'(l_ox);
    s2y = (W+2)'(l_y1) + (W+2)'(l_fy) - (W+2)'(l_oy);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      l_vld     <= 1'b0;
      res_valid <= 1'b0;
    end else if (en) begin
      l_vld   <= lt[QW-1].vld;
      l_found <= lt[QW-1].found;
      l_x1    <= lt[QW-1].x1;
      l_y1    <= lt[QW-1].y1;
      l_fx    <= signed_mag(lt[QW-1].fqx[RW-1:0], lt[QW-1].sgx ^ lt[QW-1].kneg);
      l_fy    <= signed_mag(lt[QW-1].fqy[RW-1:0], lt[QW-1].sgy ^ lt[QW-1].kneg);
      l_ox    <= signed_mag(off_qx[RW-1:0], !lt[QW-1].sgy);
      l_oy    <= signed_mag(off_qy[RW-1:0], lt[QW-1].sgx);

      res_valid   <= l_vld;
      found       <= l_found;
      point_one_x <= l_found ? sat(s1x) : '0;
      point_one_y <= l_found ? sat(s1y) : '0;
      point_two_x <= l_found ? sat(s2x) : '0;
      point_two_y <= l_found ? sat(s2y) : '0;
    end
  end

endmodule

### hdl/cci_chk.sv
// port-level checks for the circle intersection block, bound to the top level
// depends on cci_pkg and circle_circle_intersection

module cci_chk (
  input logic                         clk,
  input logic                         rst,
  input logic                         req_stall,
  input logic                         res_valid,
  input logic                         res_stall,
  input logic                         found,
  input logic signed [cci_pkg::W-1:0] point_one_x,
  input logic signed [cci_pkg::W-1:0] point_one_y,
  input logic signed [cci_pkg::W-1:0] point_two_x,
  input logic signed [cci_pkg::W-1:0] point_two_y
);
  import cci_pkg::*;

  // no result straight out of reset
  a_reset_clear: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  // requests are held off only while a result waits
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> res_valid && res_stall)
    else $error("request stalled with no waiting result");

  // a miss carries zero points
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !found |-> point_one_x == '0 && point_one_y == '0
                            && point_two_x == '0 && point_two_y == '0)
    else $error("points not zero on a miss");

  // a stalled result holds its valid, found, point_one_x and point_two_y
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(found)
                               && $stable(point_one_x) && $stable(point_two_y))
    else $error("stalled result changed");

endmodule

bind circle_circle_intersection cci_chk u_cci_chk (
  .clk         (clk),
  .rst         (rst),
  .req_stall   (req_stall),
  .res_valid   (res_valid),
  .res_stall   (res_stall),
  .found       (found),
  .point_one_x (point_one_x),
  .point_one_y (point_one_y),
  .point_two_x (point_two_x),
  .point_two_y (point_two_y)
);

### tb/circle_circle_intersection_test.sv
// self-checking bench for circle_circle_intersection: directed table, then random requests
// results are predicted with exact wide integer math; depends on cci_pkg and the block
`timescale 1ns / 1ps

module circle_circle_intersection_test;
  import cci_pkg::*;

  localparam longint CMAX = (64'sd1 <<< (W - 1)) - 1;
  localparam longint CMIN = -CMAX - 1;
  localparam longint RMAX = (64'sd1 <<< RW) - 1;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int LONG_HOLD = 400;
  localparam int DRAIN_CYCLES = 120;
  localparam int PHASE_ITEMS = 360;

  typedef struct packed {
    logic signed [W-1:0] x1;
    logic signed [W-1:0] y1;
    logic [RW-1:0] r1;
    logic signed [W-1:0] x2;
    logic signed [W-1:0] y2;
    logic [RW-1:0] r2;
  } circle_pair_t;

  typedef struct packed {
    logic found;
    logic signed [W-1:0] p1x;
    logic signed [W-1:0] p1y;
    logic signed [W-1:0] p2x;
    logic signed [W-1:0] p2y;
  } crossing_t;

  typedef struct {
    circle_pair_t circles;
    bit typed;
    crossing_t want;
  } table_row_t;

  logic clk = 0;
  logic rst = 1;
  logic req_valid = 0;
  logic req_stall;
  logic signed [W-1:0] first_center_x = '0;
  logic signed [W-1:0] first_center_y = '0;
  logic [RW-1:0] first_radius = '0;
  logic signed [W-1:0] second_center_x = '0;
  logic signed [W-1:0] second_center_y = '0;
  logic [RW-1:0] second_radius = '0;
  logic res_valid;
  logic res_stall = 0;
  logic found;
  logic signed [W-1:0] point_one_x;
  logic signed [W-1:0] point_one_y;
  logic signed [W-1:0] point_two_x;
  logic signed [W-1:0] point_two_y;

  crossing_t pending_points[$];
  int mismatches = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  bit hold_start = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  circle_circle_intersection DUT (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall),
    .first_center_x(first_center_x), .first_center_y(first_center_y),
    .first_radius(first_radius),
    .second_center_x(second_center_x), .second_center_y(second_center_y),
    .second_radius(second_radius),
    .res_valid(res_valid), .res_stall(res_stall),
    .found(found),
    .point_one_x(point_one_x), .point_one_y(point_one_y),
    .point_two_x(point_two_x), .point_two_y(point_two_y)
  );

  always #5 clk = ~clk;

  // floor of the square root, one bit at a time
  function automatic logic [127:0] root_floor(logic [127:0] n);
    logic [127:0] res;
    logic [127:0] cand;
    res = '0;
    for (int b = 63; b >= 0; b--) begin
      cand = res | (128'd1 << b);
      if (cand * cand <= n) res = cand;
    end
    return res;
  endfunction

  // magnitude of m*v/(2*d2) rounded half away from zero, kept to radius width
  function automatic longint scaled_quot(logic [127:0] m, logic [127:0] v, logic [127:0] d2);
    logic [127:0] q;
    q = (m * v + d2) / (d2 << 1);
    if (q > 128'hFFFF_FFFF_FFFF_FFFF) q = 128'hFFFF_FFFF_FFFF_FFFF;
    return longint'(q[RW-1:0]);
  endfunction

  function automatic logic signed [W-1:0] clip(longint v);
    if (v > CMAX) v = CMAX;
    if (v < CMIN) v = CMIN;
    return v[W-1:0];
  endfunction

  // crossing points of two circles, exact integer form
  function automatic crossing_t crossings(circle_pair_t c);
    crossing_t o;
    longint x1, y1, dx, dy, adx, ady, r1, r2, rs, rd, fx, fy, ox, oy;
    logic [127:0] d2, rr1, rr2, k, hh, kk, s;
    bit kneg;
    o = '0;
    x1 = c.x1;
    y1 = c.y1;
    dx = longint'(c.x2) - x1;
    dy = longint'(c.y2) - y1;
    adx = dx < 0 ? -dx : dx;
    ady = dy < 0 ? -dy : dy;
    r1 = c.r1;
    r2 = c.r2;
    rs = r1 + r2;
    rd = r1 > r2 ? r1 - r2 : r2 - r1;
    d2 = 128'(adx) * 128'(adx) + 128'(ady) * 128'(ady);
    if (d2 == 0 || d2 > 128'(rs) * 128'(rs) || d2 < 128'(rd) * 128'(rd)) return o;
    rr1 = 128'(r1) * 128'(r1);
    rr2 = 128'(r2) * 128'(r2);
    kneg = (rr1 + d2) < rr2;
    k = kneg ? rr2 - (rr1 + d2) : (rr1 + d2) - rr2;
    fx = scaled_quot(128'(adx), k, d2);
    fy = scaled_quot(128'(ady), k, d2);
    if ((dx < 0) != kneg) fx = -fx;
    if ((dy < 0) != kneg) fy = -fy;
    // half chord, argument clamped at zero
    hh = (d2 * rr1) << 2;
    kk = k * k;
    hh = hh < kk ? '0 : hh - kk;
    s = root_floor(hh);
    ox = scaled_quot(128'(ady), s, d2);
    if (dy >= 0) ox = -ox;
    oy = scaled_quot(128'(adx), s, d2);
    if (dx < 0) oy = -oy;
    o.found = 1'b1;
    o.p1x = clip(x1 + fx + ox);
    o.p1y = clip(y1 + fy + oy);
    o.p2x = clip(x1 + fx - ox);
    o.p2y = clip(y1 + fy - oy);
    return o;
  endfunction

  function automatic circle_pair_t pair_of(longint x1, longint y1, longint r1,
                                           longint x2, longint y2, longint r2);
    circle_pair_t c;
    c.x1 = x1[W-1:0];
    c.y1 = y1[W-1:0];
    c.r1 = r1[RW-1:0];
    c.x2 = x2[W-1:0];
    c.y2 = y2[W-1:0];
    c.r2 = r2[RW-1:0];
    return c;
  endfunction

  // random request: mostly meeting circles, some apart or nested, some raw noise
  function automatic circle_pair_t random_pair();
    circle_pair_t c;
    longint x1, y1, x2, y2, span, d, r1, r2, lo, hi;
    int pick;
    pick = $urandom_range(99);
    if (pick < 10) begin
      c = {$urandom, $urandom, $urandom, $urandom, 14'($urandom)};
      return c;
    end
    span = 64'sd1 <<< $urandom_range(2, 21);
    x1 = longint'($urandom_range(0, 1 << 23)) - (1 << 22);
    y1 = longint'($urandom_range(0, 1 << 23)) - (1 << 22);
    if ($urandom_range(9) == 0) begin
      x1 = $urandom_range(1) ? CMAX : CMIN;
      y1 = $urandom_range(1) ? CMAX : CMIN;
    end
    x2 = x1 + longint'($urandom_range(0, 2 * span)) - span;
    y2 = y1 + longint'($urandom_range(0, 2 * span)) - span;
    if (x2 > CMAX) x2 = CMAX;
    if (x2 < CMIN) x2 = CMIN;
    if (y2 > CMAX) y2 = CMAX;
    if (y2 < CMIN) y2 = CMIN;
    d = longint'(root_floor(128'((x2 - x1) * (x2 - x1) + (y2 - y1) * (y2 - y1))));
    r1 = $urandom_range(0, 2 * d + 1);
    if (r1 > RMAX) r1 = RMAX;
    lo = d > r1 ? d - r1 : r1 - d;
    hi = d + r1;
    if (hi > RMAX) hi = RMAX;
    if (lo > hi) lo = hi;
    if (pick < 20) begin
      r2 = $urandom_range(1) ? hi + $urandom_range(1, 1000) : lo - $urandom_range(1, 1000);
      if (r2 < 0) r2 = 0;
      if (r2 > RMAX) r2 = RMAX;
    end else if (pick < 26) begin
      r2 = $urandom_range(1) ? hi : lo;
    end else begin
      r2 = longint'($urandom_range(lo, hi));
    end
    return pair_of(x1, y1, r1, x2, y2, r2);
  endfunction

  // drive one request, entered and left at a falling edge
  task automatic send_request(circle_pair_t c, bit typed, crossing_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    first_center_x <= c.x1;
    first_center_y <= c.y1;
    first_radius <= c.r1;
    second_center_x <= c.x2;
    second_center_y <= c.y2;
    second_radius <= c.r2;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    pending_points.push_back(typed ? want : crossings(c));
    @(negedge clk);
  endtask

  task automatic wait_drained();
    req_valid <= 1'b0;
    while (pending_points.size() != 0) @(negedge clk);
  endtask

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // result checker
  always @(posedge clk) begin
    crossing_t w;
    if (!rst && res_valid && !res_stall) begin
      if (pending_points.size() == 0) begin
        $error("result with no request outstanding");
        mismatches++;
      end else begin
        w = pending_points.pop_front();
        check_field("found", w.found, found);
        check_field("point_one_x", w.p1x, point_one_x);
        check_field("point_one_y", w.p1y, point_one_y);
        check_field("point_two_x", w.p2x, point_two_x);
        check_field("point_two_y", w.p2y, point_two_y);
      end
    end
  end

  // receiver stall, with one long hold-off early in the first random phase
  always @(negedge clk) begin
    if (hold_start && hold_left == 0) begin
      hold_left <= LONG_HOLD;
      res_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      res_stall <= 1'b1;
    end else begin
      res_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if ((req_valid && !req_stall) || (res_valid && !res_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("circle_circle_intersection_test NOT OK");
      $finish;
    end
  end

  initial begin
    table_row_t rows[$];
    crossing_t none;
    crossing_t tangent;
    int send_pcts[4];
    int stall_pcts[4];
    none = '0;
    send_pcts = '{0, 78, 0, 34};
    stall_pcts = '{0, 0, 78, 34};

    // directed table
    rows.push_back('{pair_of(0, 0, 256, 0, 0, 512), 1, none});          // same center
    rows.push_back('{pair_of(0, 0, 256, 1024, 0, 256), 1, none});       // apart
    rows.push_back('{pair_of(0, 0, 2560, 256, 0, 256), 1, none});       // nested
    rows.push_back('{pair_of(0, 0, 0, 256, 0, 0), 1, none});            // zero radii
    rows.push_back('{pair_of(CMAX, CMAX, RMAX, CMIN, CMIN, RMAX), 1, none});
    tangent = '{1'b1, 24'sd256, 24'sd0, 24'sd256, 24'sd0};
    rows.push_back('{pair_of(0, 0, 256, 512, 0, 256), 1, tangent});     // outer touch
    tangent = '{1'b1, 24'sd512, 24'sd0, 24'sd512, 24'sd0};
    rows.push_back('{pair_of(0, 0, 512, 256, 0, 256), 1, tangent});     // inner touch
    rows.push_back('{pair_of(0, 0, 0, 256, 0, 256), 1, '{1'b1, 0, 0, 0, 0}});
    rows.push_back('{pair_of(0, 0, RMAX, 256, 0, RMAX), 0, none});      // widest radii
    rows.push_back('{pair_of(CMAX, 0, 1 << 22, CMAX, 1 << 22, 1 << 22), 0, none});
    rows.push_back('{pair_of(CMIN, CMIN, 1 << 20, CMIN + (1 << 20), CMIN, 1 << 20), 0, none});
    rows.push_back('{pair_of(CMIN, CMAX, RMAX, CMIN + 4096, CMAX - 4096, RMAX - 77), 0, none});
    rows.push_back('{pair_of(100, -300, 1000, 700, 500, 900), 0, none});
    rows.push_back('{pair_of(5000, 5000, 3000, 1000, 2000, 4000), 0, none});
    rows.push_back('{pair_of(-1, -1, 1, 0, 0, 1), 0, none});
    rows.push_back('{pair_of(-7000, 3000, 2500, -9000, 1000, 1200), 0, none});

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (rows[i]) send_request(rows[i].circles, rows[i].typed, rows[i].want);
    // sender pauses until every result is back
    wait_drained();

    // random phases with different idling on both sides
    for (int p = 0; p < 4; p++) begin
      send_idle_pct = send_pcts[p];
      stall_pct = stall_pcts[p];
      if (p == 0) hold_start = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n == 2) hold_start = 1'b0;
        send_request(random_pair(), 0, none);
      end
      if (p == 1) wait_drained();
    end

    send_idle_pct = 0;
    stall_pct = 0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_points.size() == 0) begin
      $display("circle_circle_intersection_test OK");
    end else begin
      $display("circle_circle_intersection_test NOT OK");
    end
    $finish;
  end

endmodule

### files.f
hdl/cci_pkg.sv
hdl/cci_div.sv
hdl/cci_sqrt.sv
hdl/circle_circle_intersection.sv
hdl/cci_chk.sv
tb/circle_circle_intersection_test.sv
